@@ hdl/tct_pkg.sv @@
// shared types and constants of the tcp connection tracker
package tct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OPEN_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [8:0]  KEY_MUL_ADDR = 9'd333;
  localparam logic [4:0]  KEY_MUL_PORT = 5'd23;
  localparam logic [8:0]  FLAGS_SYNACK = 9'h012;
  localparam logic [8:0]  FLAGS_END    = 9'h005;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_OPENED  = 3'd1;
  localparam logic [2:0] ST_COUNTED = 3'd2;
  localparam logic [2:0] ST_CLOSED  = 3'd3;
  localparam logic [2:0] ST_NOFREE  = 3'd4;
  localparam logic [2:0] ST_REPORT  = 3'd5;

  // request travelling down the row of slot cells
  typedef struct packed {
    logic              valid;
    logic [31:0]       key;
    logic [15:0]       len;
    logic              synack;
    logic              ends;
    logic [SLOT_W-1:0] pos;
    logic              found;
    logic [SLOT_W-1:0] hit;
    logic [2:0]        status;
    logic [31:0]       total;
  } req_t;

endpackage

@@ hdl/tcp_connection_tracker.sv @@
// top level: key hashing, row of slot cells, interval counters and result register
//
// channel   signals                                   handshake
// request   kind is_tcp src_addr dst_addr src_port    start, taken when busy low
//           dst_port tcp_flags pkt_len
// result    status slot conn_bytes open_conns         done, one cycle, no stall
//           interval_bytes interval_closed
//
// a tcp packet with non-zero key walks the row of TABLE_DEPTH cells, one cell per
// cycle, before its result shows; ticks, non-tcp packets and zero keys skip the
// row. the tracker takes no new request until the last one is done.
// synchronous reset empties every slot and clears all counts; no clearing pass.
// busy drops as done rises, so a new request can be taken while the result shows.
module tcp_connection_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic        is_tcp,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [8:0]  tcp_flags,
  input  logic [15:0] pkt_len,
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  slot,
  output logic [31:0] conn_bytes,
  output logic [6:0]  open_conns,
  output logic [31:0] interval_bytes,
  output logic [15:0] interval_closed
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PROD   = 4'b0010,
    S_KEY    = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // held request
  logic        r_kind;
  logic        r_tcp;
  logic [31:0] r_saddr;
  logic [31:0] r_daddr;
  logic [15:0] r_sport;
  logic [15:0] r_dport;
  logic [8:0]  r_flags;
  logic [15:0] r_len;

  logic [31:0] prod_addr;
  logic [31:0] prod_port;
  logic [31:0] key_sum;

  tct_pkg::req_t head;
  tct_pkg::req_t head_next;
  tct_pkg::req_t link [tct_pkg::TABLE_DEPTH+1];
  tct_pkg::req_t tail;

  logic [tct_pkg::OPEN_W-1:0] open_count;
  logic [tct_pkg::OPEN_W-1:0] open_count_next;
  logic [31:0]                period_bytes;
  logic [31:0]                period_bytes_next;
  logic [15:0]                period_closed;
  logic [15:0]                period_closed_next;
  logic [32:0]                period_sum;

  logic                       done_next;
  logic [2:0]                 status_next;
  logic [tct_pkg::SLOT_W-1:0] hit_next;
  logic [31:0]                conn_bytes_next;

  assign busy    = (state != S_IDLE);
  assign key_sum = prod_addr + prod_port;
  assign tail    = link[tct_pkg::TABLE_DEPTH];

  assign link[0] = head;

  for (genvar i = 0; i < tct_pkg::TABLE_DEPTH; i++) begin : g_row
    tct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .req_in  (link[i]),
      .req_out (link[i+1])
    );
  end

  assign period_sum = {1'b0, period_bytes} + {17'd0, r_len};

  always_comb begin
    state_next         = state;
    head_next          = '0;
    done_next          = 1'b0;
    status_next        = tct_pkg::ST_IGNORED;
    hit_next           = '0;
    conn_bytes_next    = 32'd0;
    open_count_next    = open_count;
    period_bytes_next  = period_bytes;
    period_closed_next = period_closed;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PROD;
      end
      S_PROD: begin
        state_next = S_KEY;
      end
      S_KEY: begin
        if (r_kind) begin
          done_next          = 1'b1;
          status_next        = tct_pkg::ST_REPORT;
          period_bytes_next  = 32'd0;
          period_closed_next = 16'd0;
          state_next         = S_IDLE;
        end else if (!r_tcp || key_sum == 32'd0) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          head_next.valid  = 1'b1;
          head_next.key    = key_sum;
          head_next.len    = r_len;
          head_next.synack = (r_flags == tct_pkg::FLAGS_SYNACK);
          head_next.ends   = |(r_flags & tct_pkg::FLAGS_END);
          head_next.status = tct_pkg::ST_IGNORED;
          state_next       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail.valid) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (!tail.found && tail.synack) begin
            status_next = tct_pkg::ST_NOFREE;
          end else begin
            status_next = tail.status;
          end
          if (tail.status != tct_pkg::ST_IGNORED && tail.found) begin
            hit_next = tail.hit;
          end
          if (tail.status == tct_pkg::ST_OPENED) begin
            open_count_next = open_count + tct_pkg::OPEN_W'(1);
          end
          if (tail.status == tct_pkg::ST_COUNTED || tail.status == tct_pkg::ST_CLOSED) begin
            conn_bytes_next   = tail.total;
            period_bytes_next = period_sum[32] ? 32'hFFFF_FFFF : period_sum[31:0];
          end
          if (tail.status == tct_pkg::ST_CLOSED) begin
            if (open_count != '0) open_count_next = open_count - tct_pkg::OPEN_W'(1);
            if (period_closed != 16'hFFFF) period_closed_next = period_closed + 16'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      done          <= 1'b0;
      open_count    <= '0;
      period_bytes  <= 32'd0;
      period_closed <= 16'd0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      done          <= done_next;
      open_count    <= open_count_next;
      period_bytes  <= period_bytes_next;
      period_closed <= period_closed_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      r_kind  <= kind;
      r_tcp   <= is_tcp;
      r_saddr <= src_addr;
      r_daddr <= dst_addr;
      r_sport <= src_port;
      r_dport <= dst_port;
      r_flags <= tcp_flags;
      r_len   <= pkt_len;
    end
    prod_addr <= (r_saddr + r_daddr) * {23'd0, tct_pkg::KEY_MUL_ADDR};
    prod_port <= {15'd0, {1'b0, r_sport} + {1'b0, r_dport}} * {27'd0, tct_pkg::KEY_MUL_PORT};
    if (done_next) begin
      status          <= status_next;
      slot            <= 6'(hit_next);
      conn_bytes      <= conn_bytes_next;
      // on a tick the report carries the counts from before clearing
      open_conns      <= (open_count_next > tct_pkg::OPEN_W'(127)) ? 7'd127
                                                                    : 7'(open_count_next);
      interval_bytes  <= (state == S_KEY && r_kind) ? period_bytes : period_bytes_next;
      interval_closed <= (state == S_KEY && r_kind) ? period_closed : period_closed_next;
    end
  end

endmodule

@@ hdl/tct_cell.sv @@
// one table slot: holds a key and byte total, serves the passing request
module tct_cell (
  input  logic          clk,
  input  logic          rst,
  input  tct_pkg::req_t req_in,
  output tct_pkg::req_t req_out
);

  logic [31:0]   key;
  logic [31:0]   bytes;
  logic [31:0]   key_next;
  logic [31:0]   bytes_next;
  tct_pkg::req_t req_next;
  logic          is_empty;
  logic          claim;
  logic [32:0]   sum;
  logic [31:0]   sat_sum;

  assign is_empty = (key == 32'd0);
  assign claim    = req_in.valid && !req_in.found && (is_empty || key == req_in.key);
  assign sum      = {1'b0, bytes} + {17'd0, req_in.len};
  assign sat_sum  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    req_next     = req_in;
    req_next.pos = req_in.pos + tct_pkg::SLOT_W'(1);
    key_next     = key;
    bytes_next   = bytes;
    if (claim) begin
      req_next.found = 1'b1;
      req_next.hit   = req_in.pos;
      if (req_in.synack) begin
        if (is_empty) begin
          key_next        = req_in.key;
          bytes_next      = 32'd0;
          req_next.status = tct_pkg::ST_OPENED;
        end
      end else if (!is_empty) begin
        req_next.total = sat_sum;
        if (req_in.ends) begin
          key_next        = 32'd0;
          bytes_next      = 32'd0;
          req_next.status = tct_pkg::ST_CLOSED;
        end else begin
          bytes_next      = sat_sum;
          req_next.status = tct_pkg::ST_COUNTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key     <= 32'd0;
      bytes   <= 32'd0;
      req_out <= '0;
    end else begin
      key     <= key_next;
      bytes   <= bytes_next;
      req_out <= req_next;
    end
  end

endmodule
